// ----- design/ftli_pkg.sv -----
// Shared constants and types for the flow table lookup/insert block.
`timescale 1ns / 1ps
package ftli_pkg;

   localparam int TABLE_SLOTS = 4096;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int STAMP_W     = 32;
   localparam int SLOT_OUT_W  = 12;

   localparam logic [1:0] ST_HIT    = 2'd0;
   localparam logic [1:0] ST_INSERT = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;

   localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd30;
   localparam logic [STAMP_W-1:0] STAMP_MIN     = 32'd2;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [40:0] ports_proto;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [63:0] dst_high;
      logic [63:0] dst_low;
   } key_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      key_type            key;
      slot_type           home;
   } entry_type;

   function automatic slot_type next_slot(slot_type s);
      slot_type r;
      if (32'(s) == TABLE_SLOTS - 1) begin
         r = '0;
      end else begin
         r = s + slot_type'(1);
      end
      return r;
   endfunction

endpackage

// ----- design/flow_table_lookup_insert.sv -----
// Flow table with linear probing, backward-shift deletion of expired entries.
//
//  channel | dir | handshake             | beat
//  req_    | in  | req_valid/req_ready   | flow key, home slot, time
//  rsp_    | out | rsp_valid/rsp_ready   | status, slot index
//  csr_    | in  | csr_wr_en             | idle timeout
//
// Each probed slot takes a read state (entry memory read), then an evaluate
// state; each backward-shift step takes a read and an evaluate state, and a
// closing state ends the shift. Accept and result take a state each.
// After reset a clearing pass zeroes every slot of the memory;
// req_ready stays low meanwhile. A held result stalls only the finish step.
`timescale 1ns / 1ps
module flow_table_lookup_insert (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_v6,
   input  logic [63:0] req_src_addr_high,
   input  logic [63:0] req_src_addr_low,
   input  logic [63:0] req_dst_addr_high,
   input  logic [63:0] req_dst_addr_low,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   input  logic [7:0]  req_protocol,
   input  logic [11:0] req_home_slot,
   input  logic [31:0] req_now_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_slot_index,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RD     = 3'd2;
   localparam logic [2:0] S_EVAL   = 3'd3;
   localparam logic [2:0] S_SH_RD  = 3'd4;
   localparam logic [2:0] S_SH_EV  = 3'd5;
   localparam logic [2:0] S_SH_END = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   localparam ftli_pkg::slot_type SLOT_LAST = ftli_pkg::slot_type'(ftli_pkg::TABLE_SLOTS - 1);
   localparam ftli_pkg::slot_type PROBE_MAX = ftli_pkg::slot_type'(ftli_pkg::TABLE_SLOTS / 2);

   ftli_pkg::entry_type mem [ftli_pkg::TABLE_SLOTS];
   ftli_pkg::entry_type rd_q;

   logic [2:0]          state_ff, state_in;
   logic [31:0]         timeout_ff;
   ftli_pkg::key_type   key_ff, key_in;
   ftli_pkg::slot_type  home_ff, home_in;
   logic [31:0]         now_ff, now_in;
   logic [31:0]         stamp_ff, stamp_in;
   ftli_pkg::slot_type  slot_ff, slot_in;
   ftli_pkg::slot_type  cnt_ff, cnt_in;
   ftli_pkg::slot_type  hole_ff, hole_in;
   ftli_pkg::slot_type  probe_ff, probe_in;
   ftli_pkg::slot_type  steps_ff, steps_in;
   logic                skip_exp_ff, skip_exp_in;
   logic [1:0]          res_status_ff, res_status_in;
   ftli_pkg::slot_type  res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [11:0]         rsp_slot_ff, rsp_slot_in;

   logic                mem_we, rd_en;
   ftli_pkg::slot_type  wr_addr, rd_addr;
   ftli_pkg::entry_type wr_data;

   logic                expired, is_empty, key_hit, stays;
   ftli_pkg::slot_type  h;
   logic [31:0]         age;
   logic [31:0]         home32, slot32;
   ftli_pkg::key_type   req_key;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q <= mem[rd_addr];
      end
   end

   always_comb begin
      req_key.ports_proto = {req_is_v6, req_protocol, req_dst_port, req_src_port};
      req_key.src_high    = req_is_v6 ? req_src_addr_high : 64'd0;
      req_key.dst_high    = req_is_v6 ? req_dst_addr_high : 64'd0;
      req_key.src_low     = req_is_v6 ? req_src_addr_low : {32'd0, req_src_addr_low[31:0]};
      req_key.dst_low     = req_is_v6 ? req_dst_addr_low : {32'd0, req_dst_addr_low[31:0]};
      home32 = 32'(req_home_slot);
   end

   assign age      = now_ff - rd_q.stamp;
   assign expired  = (rd_q.stamp >= ftli_pkg::STAMP_MIN) && (now_ff > rd_q.stamp)
                     && (age > timeout_ff);
   assign is_empty = (rd_q.stamp == '0);
   assign key_hit  = (rd_q.key == key_ff);
   assign h        = rd_q.home;
   assign stays    = (hole_ff <= probe_ff) ? ((hole_ff < h) && (h <= probe_ff))
                                           : ((hole_ff < h) || (h <= probe_ff));
   assign slot32   = 32'(res_slot_ff);

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      home_in       = home_ff;
      now_in        = now_ff;
      stamp_in      = stamp_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      hole_in       = hole_ff;
      probe_in      = probe_ff;
      steps_in      = steps_ff;
      skip_exp_in   = skip_exp_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      wr_addr       = slot_ff;
      rd_addr       = slot_ff;
      wr_data       = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we  = 1'b1;
            wr_addr = slot_ff;
            slot_in = slot_ff + ftli_pkg::slot_type'(1);
            if (slot_ff == SLOT_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               key_in      = req_key;
               home_in     = home32[ftli_pkg::SLOT_W-1:0];
               slot_in     = home32[ftli_pkg::SLOT_W-1:0];
               now_in      = req_now_seconds;
               stamp_in    = (req_now_seconds < ftli_pkg::STAMP_MIN) ? ftli_pkg::STAMP_MIN
                                                                    : req_now_seconds;
               cnt_in      = ftli_pkg::slot_type'(1);
               skip_exp_in = 1'b0;
               state_in    = S_RD;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = slot_ff;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            skip_exp_in = 1'b0;
            priority if (expired && !skip_exp_ff) begin
               mem_we   = 1'b1;
               wr_addr  = slot_ff;
               wr_data  = '0;
               hole_in  = slot_ff;
               probe_in = ftli_pkg::next_slot(slot_ff);
               steps_in = '0;
               state_in = S_SH_RD;
            end else if (is_empty) begin
               mem_we        = 1'b1;
               wr_addr       = slot_ff;
               wr_data.stamp = stamp_ff;
               wr_data.key   = key_ff;
               wr_data.home  = home_ff;
               res_status_in = ftli_pkg::ST_INSERT;
               res_slot_in   = slot_ff;
               state_in      = S_FIN;
            end else if (key_hit) begin
               mem_we        = 1'b1;
               wr_addr       = slot_ff;
               wr_data       = rd_q;
               wr_data.stamp = stamp_ff;
               res_status_in = ftli_pkg::ST_HIT;
               res_slot_in   = slot_ff;
               state_in      = S_FIN;
            end else if (cnt_ff == PROBE_MAX) begin
               res_status_in = ftli_pkg::ST_FULL;
               res_slot_in   = '0;
               state_in      = S_FIN;
            end else begin
               cnt_in   = cnt_ff + ftli_pkg::slot_type'(1);
               slot_in  = ftli_pkg::next_slot(slot_ff);
               state_in = S_RD;
            end
         end
         S_SH_RD: begin
            rd_en    = 1'b1;
            rd_addr  = probe_ff;
            state_in = S_SH_EV;
         end
         S_SH_EV: begin
            if (is_empty) begin
               state_in = S_SH_END;
            end else begin
               if (!stays) begin
                  mem_we  = 1'b1;
                  wr_addr = hole_ff;
                  wr_data = rd_q;
                  hole_in = probe_ff;
               end
               probe_in = ftli_pkg::next_slot(probe_ff);
               steps_in = steps_ff + ftli_pkg::slot_type'(1);
               state_in = (steps_ff == SLOT_LAST) ? S_SH_END : S_SH_RD;
            end
         end
         S_SH_END: begin
            // the last hole may still hold a moved entry
            mem_we      = 1'b1;
            wr_addr     = hole_ff;
            wr_data     = '0;
            skip_exp_in = 1'b1;
            state_in    = S_RD;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = slot32[ftli_pkg::SLOT_OUT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_ff      <= '0;
         timeout_ff   <= ftli_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         skip_exp_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         skip_exp_ff  <= skip_exp_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      home_ff       <= home_in;
      now_ff        <= now_in;
      stamp_ff      <= stamp_in;
      cnt_ff        <= cnt_in;
      hole_ff       <= hole_in;
      probe_ff      <= probe_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

`ifndef SYNTHESIS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && rd_en && (wr_addr == rd_addr)))
      else $error("entry memory read and write to same slot in one cycle");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ftli_pkg::ST_FULL)) |-> (rsp_slot_index == '0))
      else $error("full result with nonzero slot");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == ftli_pkg::ST_HIT) || (rsp_status == ftli_pkg::ST_INSERT)
                     || (rsp_status == ftli_pkg::ST_FULL)))
      else $error("bad result status");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_fin_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid)
      else $error("finished result not presented");
`endif

endmodule

// ----- bench/flow_table_lookup_insert_test.sv -----
// Testbench for flow_table_lookup_insert: directed table, then random traffic.
`timescale 1ns / 1ps
module flow_table_lookup_insert_test;

   typedef struct {
      logic        v6;
      logic [63:0] sh, sl, dh, dl;
      logic [15:0] sp, dp;
      logic [7:0]  proto;
      logic [11:0] home;
      logic [31:0] now;
   } flow_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] slot;
   } flow_rsp_type;

   typedef struct {
      flow_req_type r;
      bit           typed;
      logic [1:0]   status;
      logic [11:0]  slot;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_is_v6 = 0;
   logic [63:0] req_src_addr_high = 0, req_src_addr_low = 0;
   logic [63:0] req_dst_addr_high = 0, req_dst_addr_low = 0;
   logic [15:0] req_src_port = 0, req_dst_port = 0;
   logic [7:0]  req_protocol = 0;
   logic [11:0] req_home_slot = 0;
   logic [31:0] req_now_seconds = 2;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_slot_index;
   logic        csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;

   flow_table_lookup_insert u_top (.*);

   always #1 clock = ~clock;

   // shadow table
   logic [31:0]        tab_stamp [ftli_pkg::TABLE_SLOTS];
   ftli_pkg::key_type  tab_key   [ftli_pkg::TABLE_SLOTS];
   ftli_pkg::slot_type tab_home  [ftli_pkg::TABLE_SLOTS];
   logic [31:0]        idle_timeout;

   flow_rsp_type pending_rsp[$];
   int           mismatches = 0;
   int           n_hit = 0, n_ins = 0, n_full = 0, n_rsp = 0;
   bit           idle_on = 1;
   bit           hold_rsp = 0;
   bit           done_rsp = 0;

   function automatic ftli_pkg::slot_type step(ftli_pkg::slot_type s);
      return (int'(s) == ftli_pkg::TABLE_SLOTS - 1) ? ftli_pkg::slot_type'(0)
                                                     : s + ftli_pkg::slot_type'(1);
   endfunction

   function automatic bit aged_out(ftli_pkg::slot_type s, logic [31:0] now);
      logic [31:0] st;
      st = tab_stamp[s];
      if (st < 2 || now <= st) return 0;
      return (now - st) > idle_timeout;
   endfunction

   function automatic void clear_entry(ftli_pkg::slot_type s);
      tab_stamp[s] = 0;
      tab_key[s]   = '0;
      tab_home[s]  = '0;
   endfunction

   function automatic void evict(ftli_pkg::slot_type hole);
      ftli_pkg::slot_type p, h;
      bit stays;
      p = hole;
      clear_entry(hole);
      for (int n = 0; n < ftli_pkg::TABLE_SLOTS; n++) begin
         p = step(p);
         if (tab_stamp[p] == 0) break;
         h = tab_home[p];
         if (hole <= p) stays = (hole < h) && (h <= p);
         else stays = (hole < h) || (h <= p);
         if (!stays) begin
            tab_stamp[hole] = tab_stamp[p];
            tab_key[hole]   = tab_key[p];
            tab_home[hole]  = tab_home[p];
            clear_entry(p);
            hole = p;
         end
      end
   endfunction

   function automatic flow_rsp_type lookup_insert(flow_req_type r);
      ftli_pkg::key_type  k;
      ftli_pkg::slot_type s;
      logic [31:0]        st;
      flow_rsp_type       o;
      k.src_high    = r.v6 ? r.sh : 64'd0;
      k.dst_high    = r.v6 ? r.dh : 64'd0;
      k.src_low     = r.v6 ? r.sl : {32'd0, r.sl[31:0]};
      k.dst_low     = r.v6 ? r.dl : {32'd0, r.dl[31:0]};
      k.ports_proto = {r.v6, r.proto, r.dp, r.sp};
      s  = ftli_pkg::slot_type'(r.home);
      st = (r.now < 2) ? 32'd2 : r.now;
      for (int p = 1; p <= ftli_pkg::TABLE_SLOTS / 2; p++) begin
         if (aged_out(s, r.now)) evict(s);
         if (tab_stamp[s] == 0) begin
            tab_stamp[s] = st;
            tab_key[s]   = k;
            tab_home[s]  = ftli_pkg::slot_type'(r.home);
            o.status = ftli_pkg::ST_INSERT;
            o.slot   = 12'(s);
            return o;
         end
         if (tab_key[s] == k) begin
            tab_stamp[s] = st;
            o.status = ftli_pkg::ST_HIT;
            o.slot   = 12'(s);
            return o;
         end
         s = step(s);
      end
      o.status = ftli_pkg::ST_FULL;
      o.slot   = '0;
      return o;
   endfunction

   task automatic idle_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
   endtask

   // drive one beat, wait for acceptance, record expectation
   task automatic send(flow_req_type r, bit typed = 0, logic [1:0] st = 0,
                       logic [11:0] sl = 0);
      flow_rsp_type o;
      idle_gap();
      @(negedge clock);
      req_valid         <= 1;
      req_is_v6         <= r.v6;
      req_src_addr_high <= r.sh;
      req_src_addr_low  <= r.sl;
      req_dst_addr_high <= r.dh;
      req_dst_addr_low  <= r.dl;
      req_src_port      <= r.sp;
      req_dst_port      <= r.dp;
      req_protocol      <= r.proto;
      req_home_slot     <= r.home;
      req_now_seconds   <= r.now;
      do @(posedge clock); while (!(req_valid && req_ready));
      o = lookup_insert(r);
      if (typed) begin
         o.status = st;
         o.slot   = sl;
      end
      unique case (o.status)
         ftli_pkg::ST_HIT:    n_hit++;
         ftli_pkg::ST_INSERT: n_ins++;
         default:             n_full++;
      endcase
      pending_rsp.push_back(o);
   endtask

   task automatic write_timeout(logic [31:0] v);
      @(negedge clock);
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= v;
      idle_timeout = v;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   // result checker
   always @(posedge clock) begin
      flow_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: status %0d slot %0d",
                                           rsp_status, rsp_slot_index);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status || rsp_slot_index !== e.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d: expected status %0d slot %0d, got %0d slot %0d",
                           n_rsp, e.status, e.slot, rsp_status, rsp_slot_index);
            end
         end
      end
   end

   // result side ready with bursts of stall and one long hold
   initial begin
      @(negedge clock);
      while (!done_rsp) begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   flow_req_type pool[48];
   dir_row_type  rows[$];
   logic [31:0]  t_now;

   function automatic flow_req_type rand_key(bit window);
      flow_req_type r;
      r.v6    = 1'($urandom_range(0, 1));
      r.sh    = {$urandom, $urandom};
      r.sl    = {$urandom, $urandom};
      r.dh    = {$urandom, $urandom};
      r.dl    = {$urandom, $urandom};
      r.sp    = 16'($urandom);
      r.dp    = 16'($urandom);
      r.proto = 8'($urandom);
      r.home  = window ? 12'($urandom_range(0, 255)) : 12'($urandom);
      r.now   = 32'd2;
      return r;
   endfunction

   function automatic void add_row(flow_req_type r, bit typed = 0,
                                   logic [1:0] st = 0, logic [11:0] sl = 0);
      dir_row_type d;
      d.r = r; d.typed = typed; d.status = st; d.slot = sl;
      rows.push_back(d);
   endfunction

   initial begin
      flow_req_type a, b, c, x;
      logic [31:0] tmo_set[4];
      int sel;
      for (int i = 0; i < ftli_pkg::TABLE_SLOTS; i++) clear_entry(ftli_pkg::slot_type'(i));
      idle_timeout = ftli_pkg::TIMEOUT_RESET;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      a = '{0, 0, 64'h0A000001, 0, 64'h0A000002, 1000, 80, 6, 5, 100};
      add_row(a, 1, ftli_pkg::ST_INSERT, 5);
      add_row(a, 1, ftli_pkg::ST_HIT, 5);
      x = a; x.sh = '1; x.dh = '1; x.sl[63:32] = '1; x.dl[63:32] = '1; x.now = 101;
      add_row(x, 1, ftli_pkg::ST_HIT, 5);
      x = a; x.v6 = 1; x.now = 101;
      add_row(x, 1, ftli_pkg::ST_INSERT, 6);
      b = '{1, '1, '1, '1, '1, '1, '1, '1, 4095, '1};
      add_row(b, 1, ftli_pkg::ST_INSERT, 4095);
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 4095, 0};
      add_row(c, 1, ftli_pkg::ST_INSERT, 0);
      c.now = 1;
      add_row(c);
      x = a; x.sp = 1; x.now = 50;
      add_row(x);
      x = a; x.home = 6; x.dp = 443; x.now = 1000;
      add_row(x);
      x = a; x.now = 1000;
      add_row(x);
      x = a; x.proto = 17; x.now = 1001;
      add_row(x);
      x = a; x.dp = 81; x.now = 1002;
      add_row(x);
      x = b; x.now = 1003;
      add_row(x);
      foreach (rows[i]) send(rows[i].r, rows[i].typed, rows[i].status, rows[i].slot);

      foreach (pool[i]) pool[i] = rand_key(1);
      tmo_set = '{0, '1, 5, 32'($urandom_range(1, 100))};
      t_now = 3000;
      for (int ph = 0; ph < 4; ph++) begin
         write_timeout(tmo_set[ph]);
         if (ph == 3) idle_on = 0;
         for (int i = 0; i < 475; i++) begin
            if (ph == 1 && i == 100) hold_rsp = 1;
            t_now += $urandom_range(0, 3);
            sel = $urandom_range(0, 99);
            if (sel < 75) x = pool[$urandom_range(0, 47)];
            else x = rand_key(sel < 97);
            sel = $urandom_range(0, 99);
            if (sel < 3) x.now = $urandom_range(0, 1);
            else if (sel < 6) x.now = $urandom;
            else if (sel < 9) x.now = t_now - $urandom_range(1, 40);
            else x.now = t_now;
            send(x);
         end
      end
      write_timeout($urandom);

      @(negedge clock);
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      done_rsp = 1;
      $display("covered %0d hits, %0d inserts, %0d full answers over %0d result beats",
               n_hit, n_ins, n_full, n_rsp);
      $display("idle timeouts swept through 0, max, small and random values; %0d mismatches",
               mismatches);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- flow_table_lookup_insert.f -----
design/ftli_pkg.sv
design/flow_table_lookup_insert.sv
bench/flow_table_lookup_insert_test.sv
